// File: rtl/btdf_pkg.sv
// Shared types and constants for the binary to decimal text formatter.
// No dependencies; every other file of the block imports this package.
package btdf_pkg;

    // Widths of the input fields and of one character.
    localparam int VALUE_W = 32;
    localparam int FRAC_W  = 4;
    localparam int CHAR_W  = 8;

    // Step counter of the converter: it must hold VALUE_W itself.
    localparam int STEP_W  = $clog2(VALUE_W + 1);

    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [FRAC_W-1:0]  frac_t;
    typedef logic [CHAR_W-1:0]  char_t;

    // ASCII codes that the text is built from.
    localparam char_t CHAR_ZERO = 8'h30;
    localparam char_t CHAR_NINE = 8'h39;
    localparam char_t CHAR_DOT  = 8'h2E;

    // States of the character emitter.
    typedef enum logic [1:0] {
        EMIT_IDLE,
        EMIT_WAIT,
        EMIT_DIGIT,
        EMIT_DOT
    } emit_state_t;

endpackage

// File: rtl/btdf_dabble.sv
// Bit-serial binary to BCD converter (shift and add three, one bit per cycle).
// Depends on btdf_pkg.
module btdf_dabble #(
    parameter int DIGITS = 10
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    input  btdf_pkg::value_t        value,
    output logic                    done,
    output logic [4*DIGITS-1:0]     bcd
);
    import btdf_pkg::*;

    localparam int BCD_W = 4 * DIGITS;

    value_t            bin_reg,  bin_next;
    logic [BCD_W-1:0]  bcd_reg,  bcd_next;
    logic [STEP_W-1:0] cnt_reg,  cnt_next;
    logic              done_reg, done_next;
    logic [BCD_W-1:0]  adjusted;

    // Each decimal digit of five or more gets three added before the shift.
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                adjusted[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                adjusted[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    // One binary bit enters the BCD register per cycle; the top carry is dropped.
    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (load)
        begin
            bin_next = value;
            bcd_next = '0;
            cnt_next = STEP_W'(VALUE_W);
        end
        else if (cnt_reg != '0)
        begin
            bin_next  = bin_reg << 1;
            bcd_next  = (adjusted << 1) | BCD_W'(bin_reg[VALUE_W-1]);
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == STEP_W'(1));
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // Data shift registers.
    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

// File: rtl/btdf_emitter.sv
// Character emitter: walks the BCD digits from the most significant one,
// suppresses leading zeros, inserts the decimal point and registers the output.
// Depends on btdf_pkg.
module btdf_emitter #(
    parameter int DIGITS = 10
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  btdf_pkg::frac_t         frac_digits,
    input  logic                    conv_done,
    input  logic [4*DIGITS-1:0]     bcd,
    output logic                    busy,
    output btdf_pkg::char_t         char_code,
    output logic                    last,
    output logic                    char_strobe
);
    import btdf_pkg::*;

    localparam int BCD_W = 4 * DIGITS;
    localparam int POS_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    emit_state_t       state_reg, state_next;
    logic [BCD_W-1:0]  dig_reg,   dig_next;
    logic [POS_W-1:0]  pos_reg,   pos_next;
    logic              lead_reg,  lead_next;
    logic [POS_W-1:0]  int_last_reg, int_last_next;
    logic              has_frac_reg, has_frac_next;
    char_t             char_reg,  char_next;
    logic              last_reg,  last_next;
    logic              strobe_reg, strobe_next;
    logic [3:0]        digit;
    logic              skip;

    // Position of the last integer digit, with the fraction count saturated
    // so that at least one integer digit remains.
    always_comb
    begin
        int fsat;
        if (int'(frac_digits) > DIGITS - 1)
        begin
            fsat = DIGITS - 1;
        end
        else
        begin
            fsat = int'(frac_digits);
        end
        int_last_next = POS_W'(DIGITS - 1 - fsat);
        has_frac_next = (fsat != 0);
    end

    assign digit = dig_reg[BCD_W-1 -: 4];
    assign skip  = lead_reg && (digit == 4'd0) && (pos_reg != int_last_reg);

    // Next state and output character.
    always_comb
    begin
        state_next  = state_reg;
        dig_next    = dig_reg;
        pos_next    = pos_reg;
        lead_next   = lead_reg;
        char_next   = char_reg;
        last_next   = last_reg;
        strobe_next = 1'b0;
        unique case (state_reg)
            EMIT_IDLE:
            begin
                if (start)
                begin
                    state_next = EMIT_WAIT;
                end
            end
            EMIT_WAIT:
            begin
                if (conv_done)
                begin
                    dig_next   = bcd;
                    pos_next   = '0;
                    lead_next  = 1'b1;
                    state_next = EMIT_DIGIT;
                end
            end
            EMIT_DIGIT:
            begin
                dig_next = dig_reg << 4;
                pos_next = pos_reg + 1'b1;
                if (!skip)
                begin
                    lead_next   = 1'b0;
                    char_next   = CHAR_ZERO + CHAR_W'(digit);
                    last_next   = (pos_reg == POS_W'(DIGITS - 1));
                    strobe_next = 1'b1;
                end
                if (pos_reg == POS_W'(DIGITS - 1))
                begin
                    state_next = EMIT_IDLE;
                end
                else if (has_frac_reg && (pos_reg == int_last_reg))
                begin
                    state_next = EMIT_DOT;
                end
            end
            EMIT_DOT:
            begin
                char_next   = CHAR_DOT;
                last_next   = 1'b0;
                strobe_next = 1'b1;
                state_next  = EMIT_DIGIT;
            end
            default:
            begin
                state_next = EMIT_IDLE;
            end
        endcase
    end

    // State register and strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= EMIT_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    // Digit shift register, position and output payload.
    always_ff @(posedge clk)
    begin
        dig_reg  <= dig_next;
        pos_reg  <= pos_next;
        lead_reg <= lead_next;
        char_reg <= char_next;
        last_reg <= last_next;
        if ((state_reg == EMIT_IDLE) && start)
        begin
            int_last_reg <= int_last_next;
            has_frac_reg <= has_frac_next;
        end
    end

    assign busy        = (state_reg != EMIT_IDLE);
    assign char_code   = char_reg;
    assign last        = last_reg;
    assign char_strobe = strobe_reg;

endmodule

// File: rtl/binary_to_decimal_text_formatter_unit.sv
// Top level of the binary to decimal text formatter.
// Depends on btdf_pkg, btdf_dabble and btdf_emitter.
//
// A number is taken with start while busy is low. Its 32 bits are shifted into
// a BCD register one bit per cycle, then the DIGITS decimal digits are walked
// one per cycle, with an extra step for the decimal point when there is a
// fraction part. Busy stays high through the bit-serial conversion and the walk.
// Suppressed leading zeros are still walked but give no character. Each
// character appears for one cycle with char_strobe high and cannot be held off;
// the last one carries last and coincides with busy going low, so the next
// number may start then.
// Only the low DIGITS decimal digits of the value are shown.
module binary_to_decimal_text_formatter_unit #(
    parameter int DIGITS = 10
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  btdf_pkg::value_t value,
    input  btdf_pkg::frac_t  frac_digits,
    output btdf_pkg::char_t  char_code,
    output logic             last,
    output logic             char_strobe
);
    import btdf_pkg::*;

    logic                  accept;
    logic                  conv_done;
    logic [4*DIGITS-1:0]   bcd;

    // A transfer is taken when start meets an idle unit.
    assign accept = start && !busy;

    btdf_dabble #(
        .DIGITS (DIGITS)
    ) u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (accept),
        .value (value),
        .done  (conv_done),
        .bcd   (bcd)
    );

    btdf_emitter #(
        .DIGITS (DIGITS)
    ) u_emitter (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (accept),
        .frac_digits (frac_digits),
        .conv_done   (conv_done),
        .bcd         (bcd),
        .busy        (busy),
        .char_code   (char_code),
        .last        (last),
        .char_strobe (char_strobe)
    );

endmodule

// File: rtl/btdf_checker.sv
// Port-level checks for the binary to decimal text formatter, bound to the top.
// Depends on btdf_pkg and binary_to_decimal_text_formatter_unit.
module btdf_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  btdf_pkg::char_t  char_code,
    input  logic             last,
    input  logic             char_strobe
);
    import btdf_pkg::*;

    // Every character transferred is a decimal digit or the point.
    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        char_strobe |-> ((char_code >= CHAR_ZERO && char_code <= CHAR_NINE)
                         || char_code == CHAR_DOT))
        else $error("character outside digits and point");

    // An accepted number makes the unit busy.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after a transfer was taken");

    // The final character ends the text: nothing follows it at once.
    a_last_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (char_strobe && last) |=> !char_strobe)
        else $error("character directly after the last one");

    // Busy falls exactly with the final character.
    a_fall_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (char_strobe && last))
        else $error("busy fell without the last character");

endmodule

bind binary_to_decimal_text_formatter_unit btdf_checker u_btdf_checker (.*);
